// ===== hdl/fixed_block_pool_allocator_macros.svh =====
// Assertion macros for the block pool allocator.
// Both forms assume a clock named i_clk and an active-low reset named i_rst_n.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FBPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`else

`define FBPA_ASSERT_IMPL(label, ante, cons)
`define FBPA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/fbpa_pkg.sv =====
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 256;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int CNT_W     = 9;
    localparam int SPAN_W    = CNT_W + SIZE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] MAX_BLOCK_SIZE = SIZE_W'(65536);
    localparam logic [SIZE_W-1:0] ALIGN_MASK     = SIZE_W'(63);

    localparam logic [ADDR_W-1:0] BASE_RST  = '0;
    localparam logic [SIZE_W-1:0] BSIZE_RST = SIZE_W'(64);
    localparam logic [CNT_W-1:0]  BCOUNT_RST = CNT_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        t_status           status;
        logic [CNT_W-1:0]  available;
    } t_out;

    // Effective pool configuration seen by the stack logic.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] asize;
        logic [CNT_W-1:0]  ecount;
        logic [SPAN_W-1:0] span;
        logic              refill;
    } t_cfg;

    // Clamp to 1..65536 and round up to a multiple of 64.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] c;
        c = s;
        if (c == '0) begin
            c = SIZE_W'(1);
        end else if (c > MAX_BLOCK_SIZE) begin
            c = MAX_BLOCK_SIZE;
        end
        return (c + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

endpackage

// ===== hdl/fbpa_ram.sv =====
module fbpa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fbpa_cfg.sv =====
module fbpa_cfg
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (r == '0) begin
            r = CNT_W'(1);
        end else if (32'(r) > MAX_BLOCKS) begin
            r = CNT_W'(MAX_BLOCKS);
        end
        return r;
    endfunction

    localparam logic [SIZE_W-1:0] ASIZE_RST  = eff_size(BSIZE_RST);
    localparam logic [CNT_W-1:0]  ECOUNT_RST = eff_count(BCOUNT_RST);

    logic [ADDR_W-1:0] r_base,   n_base;
    logic [SIZE_W-1:0] r_bsize,  n_bsize;
    logic [CNT_W-1:0]  r_bcount, n_bcount;
    logic [SIZE_W-1:0] r_asize,  n_asize;
    logic [CNT_W-1:0]  r_ecount, n_ecount;
    logic [SPAN_W-1:0] r_span,   n_span;
    logic              r_refill, n_refill;

    always_comb begin
        n_base   = r_base;
        n_bsize  = r_bsize;
        n_bcount = r_bcount;
        n_refill = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE: begin
                    n_base   = i_cfg_wdata;
                    n_refill = 1'b1;
                end
                CFG_SIZE: begin
                    n_bsize  = i_cfg_wdata[SIZE_W-1:0];
                    n_refill = 1'b1;
                end
                CFG_COUNT: begin
                    n_bcount = i_cfg_wdata[CNT_W-1:0];
                    n_refill = 1'b1;
                end
                default: begin
                    // unknown index: ignored, no refill
                end
            endcase
        end
        n_asize  = eff_size(n_bsize);
        n_ecount = eff_count(n_bcount);
        n_span   = SPAN_W'(n_ecount) * SPAN_W'(n_asize);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RST;
            r_bsize  <= BSIZE_RST;
            r_bcount <= BCOUNT_RST;
            r_asize  <= ASIZE_RST;
            r_ecount <= ECOUNT_RST;
            r_span   <= SPAN_W'(ECOUNT_RST) * SPAN_W'(ASIZE_RST);
            r_refill <= 1'b1;
        end else begin
            r_base   <= n_base;
            r_bsize  <= n_bsize;
            r_bcount <= n_bcount;
            r_asize  <= n_asize;
            r_ecount <= n_ecount;
            r_span   <= n_span;
            r_refill <= n_refill;
        end
    end

    assign o_cfg = '{base:   r_base,
                     asize:  r_asize,
                     ecount: r_ecount,
                     span:   r_span,
                     refill: r_refill};

endmodule

// ===== hdl/fbpa_stack.sv =====
module fbpa_stack
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_acc,
    input  t_in  i_item,
    output t_out o_res
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int OFF_W = IDX_W + 16;

    logic [CNT_W-1:0]      r_count;
    logic [MAX_BLOCKS-1:0] r_vbit;

    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  n_count;
    t_status           n_status;
    logic              n_ok;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W:0]   region_end;
    logic              addr_bad;
    logic [OFF_W-1:0]  wr_off;
    logic [OFF_W-1:0]  rd_off;
    logic [OFF_W-1:0]  sel_off;

    t_status           r_s1_status;
    logic [CNT_W-1:0]  r_s1_avail;
    logic              r_s1_ok;
    logic              r_s1_vbit;
    logic [OFF_W-1:0]  r_s1_dflt;

    // Count is reloaded from the config the cycle after reset or a config write.
    assign cur_count  = i_cfg.refill ? i_cfg.ecount : r_count;
    assign region_end = {1'b0, i_cfg.base} + (ADDR_W + 1)'(i_cfg.span);
    assign addr_bad   = (i_item.address == '0) || (i_item.address < i_cfg.base) ||
                        ({1'b0, i_item.address} >= region_end);
    assign wr_off     = OFF_W'(i_item.address - i_cfg.base);

    always_comb begin
        n_count  = cur_count;
        n_status = ST_DONE;
        n_ok     = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        idx      = IDX_W'(cur_count);
        if (!i_item.action) begin
            idx = IDX_W'(cur_count - CNT_W'(1));
            if (cur_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = cur_count - CNT_W'(1);
                n_ok    = 1'b1;
                mem_re  = i_acc;
            end
        end else begin
            priority if (addr_bad) begin
                n_status = ST_BAD_ADDR;
            end else if (cur_count >= i_cfg.ecount) begin
                n_status = ST_FULL;
            end else begin
                n_count = cur_count + CNT_W'(1);
                mem_we  = i_acc;
            end
        end
    end

    fbpa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (wr_off),
        .i_re    (mem_re),
        .i_raddr (idx),
        .o_rdata (rd_off)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vbit  <= '0;
        end else begin
            r_count <= i_acc ? n_count : cur_count;
            r_vbit  <= (i_cfg.refill ? '0 : r_vbit) |
                       (mem_we ? (MAX_BLOCKS'(1) << idx) : '0);
        end
    end

    // Entries never written since the last refill read as i * aligned size.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_status <= n_status;
            r_s1_avail  <= n_count;
            r_s1_ok     <= n_ok;
            r_s1_vbit   <= r_vbit[idx] && !i_cfg.refill;
            r_s1_dflt   <= OFF_W'(idx) * OFF_W'(i_cfg.asize);
        end
    end

    assign sel_off = r_s1_vbit ? rd_off : r_s1_dflt;

    assign o_res = '{block_address: r_s1_ok ? i_cfg.base + ADDR_W'(sel_off) : '0,
                     status:        r_s1_status,
                     available:     r_s1_avail};

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+---------------------------
// request  | i_in_valid   | o_in_stall   | i_in_data  (t_in)
// result   | o_out_valid  | i_out_stall  | o_out_data (t_out)
// config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_wdata
//
// One request per cycle while o_in_stall is low; each result passes through
// the decision stage with the stack RAM read, then the output register.
// Synchronous active-low reset; the stack is refilled on reset and on every
// mapped config write by clearing per-entry valid bits, no clearing pass.
// A stalled result holds the output register; the decision stage keeps
// taking requests until both it and the output register are full.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data
);

`include "fixed_block_pool_allocator_macros.svh"

    t_cfg w_cfg;
    t_out w_res;
    logic acc;
    logic s1_move;
    logic r_s1_vld;
    logic r_out_vld;
    t_out r_out;

    assign s1_move    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_s1_vld && r_out_vld && i_out_stall);
    assign acc        = i_in_valid && !o_in_stall;

    fbpa_cfg #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    fbpa_stack #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_acc   (acc),
        .i_item  (i_in_data),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= acc || (r_s1_vld && !s1_move);
            r_out_vld <= s1_move || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `FBPA_ASSERT_IMPL(a_avail_bound, o_out_valid, o_out_data.available <= w_cfg.ecount)
    `FBPA_ASSERT_IMPL(a_fail_null, o_out_valid && (o_out_data.status != ST_DONE), o_out_data.block_address == '0)
    `FBPA_ASSERT_NEXT(a_acc_fills, acc, r_s1_vld)

endmodule

// ===== dv/fixed_block_pool_allocator_tb.sv =====
module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam int          DEPTH      = MAX_BLOCKS_DEF;
    localparam int unsigned GRAIN      = 64;
    localparam logic        ACT_ALLOC  = 1'b0;
    localparam logic        ACT_FREE   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ADDR_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;

    fixed_block_pool_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // pool shadow: raw registers, offset stack and free count
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] pool_bsize;
    logic [CNT_W-1:0]  pool_bcount;
    logic [31:0]       free_offsets [DEPTH];
    int unsigned       free_avail;

    t_in  request_queue [$];
    t_out expected_replies [$];

    logic req_taken = 1'b0;
    logic no_idle = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   n_requests = 0;
    int   n_writes = 0;
    int   n_settings = 0;
    int   status_seen [4] = '{0, 0, 0, 0};

    function automatic int unsigned block_bytes(input logic [SIZE_W-1:0] raw);
        int unsigned s;
        s = raw;
        if (s == 0) s = 1;
        if (s > 65536) s = 65536;
        return (s + GRAIN - 1) / GRAIN * GRAIN;
    endfunction

    function automatic int unsigned block_total(input logic [CNT_W-1:0] raw);
        int unsigned c;
        c = raw;
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic void pool_refill();
        int unsigned asz;
        asz = block_bytes(pool_bsize);
        for (int i = 0; i < DEPTH; i++) free_offsets[i] = i * asz;
        free_avail = block_total(pool_bcount);
    endfunction

    function automatic void pool_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [ADDR_W-1:0] data);
        case (idx)
            CFG_BASE:  pool_base = data;
            CFG_SIZE:  pool_bsize = data[SIZE_W-1:0];
            CFG_COUNT: pool_bcount = data[CNT_W-1:0];
            default:   return;  // unmapped index: no refill
        endcase
        pool_refill();
    endfunction

    function automatic t_out pool_predict(input t_in req);
        t_out            r;
        longint unsigned lo, hi;
        int unsigned     cnt;
        cnt = block_total(pool_bcount);
        r.block_address = '0;
        r.status = ST_DONE;
        if (req.action == ACT_ALLOC) begin
            if (free_avail == 0) begin
                r.status = ST_EMPTY;
            end else begin
                free_avail--;
                r.block_address = pool_base + free_offsets[free_avail];
            end
        end else begin
            // region end is computed without 32-bit wrap
            lo = pool_base;
            hi = lo + 64'(cnt) * 64'(block_bytes(pool_bsize));
            if (req.address == '0 || req.address < lo || req.address >= hi) begin
                r.status = ST_BAD_ADDR;
            end else if (free_avail >= cnt) begin
                r.status = ST_FULL;
            end else begin
                free_offsets[free_avail] = req.address - pool_base;
                free_avail++;
            end
        end
        r.available = CNT_W'(free_avail);
        n_requests++;
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic void add_request(input logic act, input logic [ADDR_W-1:0] addr);
        t_in t;
        t.action = act;
        t.address = addr;
        request_queue.push_back(t);
    endfunction

    // mostly block starts, some interior, edge, null and wild addresses
    function automatic logic [ADDR_W-1:0] free_target();
        int unsigned asz, cnt, k;
        logic [ADDR_W-1:0] a;
        asz = block_bytes(pool_bsize);
        cnt = block_total(pool_bcount);
        k = $urandom_range(0, 9);
        if (k < 6) a = pool_base + $urandom_range(0, cnt - 1) * asz;
        else if (k == 6) a = pool_base + $urandom_range(0, cnt * asz - 1);
        else if (k == 7) a = pool_base + cnt * asz - $urandom_range(0, 1);
        else if (k == 8) a = $urandom_range(0, 1) ? '0 : pool_base - 1;
        else a = $urandom();
        return a;
    endfunction

    function automatic void queue_traffic(input int n);
        int kind, len, cap;
        cap = block_total(pool_bcount) + 2;
        if (cap > 30) cap = 30;
        while (n > 0) begin
            kind = $urandom_range(0, 3);
            len = (kind < 2) ? $urandom_range(1, cap) : $urandom_range(1, 10);
            for (int j = 0; j < len && n > 0; j++, n--) begin
                if (kind == 0 || (kind >= 2 && $urandom_range(0, 1) == 0))
                    add_request(ACT_ALLOC, $urandom());
                else
                    add_request(ACT_FREE, free_target());
            end
        end
    endfunction

    // run the pool dry, then free cnt + 2 random block starts to refill and overflow it
    function automatic void empty_then_full();
        int unsigned cnt, asz;
        cnt = block_total(pool_bcount);
        asz = block_bytes(pool_bsize);
        for (int unsigned j = 0; j < cnt + 2; j++) add_request(ACT_ALLOC, $urandom());
        for (int unsigned j = 0; j < cnt + 2; j++)
            add_request(ACT_FREE, pool_base + $urandom_range(0, cnt - 1) * asz);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        pool_write_reg(idx, data);
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (request_queue.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // request driver and result stall driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(0, 12);
                        i_in_valid <= 1'b0;
                    end else begin
                        i_in_data <= request_queue.pop_front();
                        i_in_valid <= 1'b1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor: predict on request transfer, compare on result transfer
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            req_taken = i_in_valid && !o_in_stall;
            if (req_taken) expected_replies.push_back(pool_predict(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    check_field("block_address", exp_r.block_address,
                                o_out_data.block_address);
                    check_field("status", 32'(exp_r.status), 32'(o_out_data.status));
                    check_field("available", 32'(exp_r.available), 32'(o_out_data.available));
                end
            end
            if (req_taken || (o_out_valid && !i_out_stall) || i_cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("** fixed_block_pool_allocator: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] b;
        logic [SIZE_W-1:0] s;
        logic [CNT_W-1:0]  c;
        bit                wrote;
        pool_base = BASE_RST;
        pool_bsize = BSIZE_RST;
        pool_bcount = BCOUNT_RST;
        pool_refill();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool: 256 blocks of 64 bytes at address 0
        add_request(ACT_FREE, 32'h0000_0000);     // null, though inside the region
        add_request(ACT_FREE, 32'h0000_0040);     // stack already full
        add_request(ACT_FREE, 32'h0000_4000);     // exactly at region end
        add_request(ACT_FREE, 32'hFFFF_FFFF);
        add_request(ACT_ALLOC, 32'hFFFF_FFFF);
        add_request(ACT_FREE, 32'h0000_3FFF);     // last byte, unaligned
        add_request(ACT_ALLOC, 32'h0000_0000);
        add_request(ACT_ALLOC, $urandom());
        wait_quiet();

        // saturated size and count, region crossing 2^32
        write_reg(CFG_BASE, 32'hFFFF_FF00);
        write_reg(CFG_SIZE, 32'h0001_FFFF);
        write_reg(CFG_COUNT, 32'h0000_01FF);
        n_settings++;
        add_request(ACT_ALLOC, $urandom());       // wrapped address
        add_request(ACT_FREE, 32'hFFFF_FFFF);
        add_request(ACT_FREE, 32'hFFFF_FF00);
        add_request(ACT_FREE, 32'h0000_0005);     // below base
        add_request(ACT_ALLOC, $urandom());
        wait_quiet();

        // zero size and zero count: one 64-byte block
        write_reg(CFG_BASE, 32'h0000_1000);
        write_reg(CFG_SIZE, 32'h0000_0000);
        write_reg(CFG_COUNT, 32'h0000_0000);
        n_settings++;
        add_request(ACT_ALLOC, $urandom());
        add_request(ACT_ALLOC, $urandom());       // empty
        add_request(ACT_FREE, 32'h0000_103F);
        add_request(ACT_ALLOC, $urandom());
        add_request(ACT_FREE, 32'h0000_1040);
        add_request(ACT_FREE, 32'h0000_0FFF);
        wait_quiet();
        // unmapped register must not refill the drained pool
        write_reg(CFG_UNUSED, $urandom());
        add_request(ACT_ALLOC, $urandom());
        add_request(ACT_FREE, 32'h0000_1000);
        add_request(ACT_FREE, 32'h0000_1000);     // full

        for (int p = 0; p < 10; p++) begin
            wait_quiet();
            if (p == 9) no_idle = 1'b1;
            case ($urandom_range(0, 3))
                0:       b = '0;
                1:       b = 32'hFFFF_FFFF;
                2:       b = $urandom();
                default: b = {16'($urandom()), 16'h0};
            endcase
            case ($urandom_range(0, 6))
                0:       s = '0;
                1:       s = SIZE_W'(1);
                2:       s = SIZE_W'(64);
                3:       s = SIZE_W'(65);
                4:       s = SIZE_W'(65536);
                5:       s = '1;
                default: s = SIZE_W'($urandom());
            endcase
            if (p == 3) c = CNT_W'(256);
            else if (p == 7) c = '1;
            else if ($urandom_range(0, 4) == 0) c = CNT_W'($urandom_range(0, 2));
            else c = CNT_W'($urandom_range(2, 24));
            wrote = 1'b0;
            if ($urandom_range(0, 4) != 0) begin
                write_reg(CFG_BASE, b);
                wrote = 1'b1;
            end
            if ($urandom_range(0, 4) != 0) begin
                write_reg(CFG_SIZE, {15'($urandom()), s});
                wrote = 1'b1;
            end
            if (!wrote || p == 3 || p == 7 || $urandom_range(0, 4) != 0)
                write_reg(CFG_COUNT, {23'($urandom()), c});
            if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, $urandom());
            n_settings++;
            if (p == 3 || p == 7) empty_then_full();
            else queue_traffic(80);
        end

        wait_quiet();
        repeat (4) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d results never arrived: expected %0d more, actual 0",
                     $time, expected_replies.size(), expected_replies.size());
            fail_count++;
        end
        $display("covered %0d requests: %0d done, %0d empty, %0d bad address, %0d full",
                 n_requests, status_seen[ST_DONE], status_seen[ST_EMPTY],
                 status_seen[ST_BAD_ADDR], status_seen[ST_FULL]);
        $display("pool settings: %0d, register writes: %0d", n_settings + 1, n_writes);
        if (fail_count == 0) begin
            $display("** fixed_block_pool_allocator: PASSED **");
        end else begin
            $display("** fixed_block_pool_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== fixed_block_pool_allocator.f =====
+incdir+hdl
hdl/fbpa_pkg.sv
hdl/fbpa_ram.sv
hdl/fbpa_cfg.sv
hdl/fbpa_stack.sv
hdl/fixed_block_pool_allocator.sv
dv/fixed_block_pool_allocator_tb.sv
